// File: sv/rau_pkg.sv
package rau_pkg;

   // Command codes.
   localparam logic [2:0] CMD_REDUCE = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_SUB    = 3'd2;
   localparam logic [2:0] CMD_MUL    = 3'd3;
   localparam logic [2:0] CMD_DIV    = 3'd4;
   localparam logic [2:0] CMD_EQ     = 3'd5;
   localparam logic [2:0] CMD_LT     = 3'd6;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // What the back end has to do with a queued item.
   typedef enum logic [1:0] {
      KIND_ARITH,
      KIND_EQ,
      KIND_LT,
      KIND_CONST
   } kind_type;

   // Control word that travels with the operands through the queue.
   typedef struct packed {
      kind_type   kind;
      logic       neg0;
      logic       neg1;
      logic       neg2;
      logic       use1;
      logic [1:0] status;
   } ctl_type;

endpackage

// File: sv/rau_queue.sv
module rau_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/rau_front.sv
module rau_front import rau_pkg::*; #(
   parameter int W = 32
) (
   input  logic                 [2:0]   command,
   input  logic signed          [W-1:0] a_num,
   input  logic signed          [W-1:0] a_den,
   input  logic signed          [W-1:0] b_num,
   input  logic                 [W-2:0] b_den,
   output logic [$bits(ctl_type)+6*W-1:0] entry
);

   ctl_type    ctl;
   logic [W-1:0] an, ad, bn, bd, one;
   logic         an_n, ad_n, bn_n;
   logic [W-1:0] x0, y0, x1, y1, x2, y2;

   // Sign and magnitude of each operand; the most negative value maps onto itself.
   assign an_n = a_num[W-1];
   assign ad_n = a_den[W-1];
   assign bn_n = b_num[W-1];
   assign an   = an_n ? W'(-a_num) : W'(a_num);
   assign ad   = ad_n ? W'(-a_den) : W'(a_den);
   assign bn   = bn_n ? W'(-b_num) : W'(b_num);
   assign bd   = {1'b0, b_den};
   assign one  = W'(1);

   // Pick the three cross products and their signs, and flag zero denominators.
   always_comb begin
      ctl.kind   = KIND_ARITH;
      ctl.neg0   = 1'b0;
      ctl.neg1   = 1'b0;
      ctl.neg2   = 1'b0;
      ctl.use1   = 1'b0;
      ctl.status = STATUS_OK;
      x0 = '0; y0 = '0; x1 = '0; y1 = '0; x2 = '0; y2 = '0;
      case (command)
         CMD_REDUCE: begin
            x0 = an; y0 = one; ctl.neg0 = an_n;
            x2 = ad; y2 = one; ctl.neg2 = ad_n;
            if (ad == '0) begin
               ctl.kind = KIND_CONST; ctl.status = STATUS_ZERO_DEN;
            end
         end
         CMD_ADD, CMD_SUB: begin
            x0 = an; y0 = bd; ctl.neg0 = an_n;
            x1 = bn; y1 = ad; ctl.neg1 = bn_n ^ ad_n ^ (command == CMD_SUB);
            x2 = ad; y2 = bd; ctl.neg2 = ad_n;
            ctl.use1 = 1'b1;
            if (ad == '0 || bd == '0) begin
               ctl.kind = KIND_CONST; ctl.status = STATUS_ZERO_DEN;
            end
         end
         CMD_MUL: begin
            x0 = an; y0 = bn; ctl.neg0 = an_n ^ bn_n;
            x2 = ad; y2 = bd; ctl.neg2 = ad_n;
            if (ad == '0 || bd == '0) begin
               ctl.kind = KIND_CONST; ctl.status = STATUS_ZERO_DEN;
            end
         end
         CMD_DIV: begin
            x0 = an; y0 = bd; ctl.neg0 = an_n;
            x2 = ad; y2 = bn; ctl.neg2 = ad_n ^ bn_n;
            if (ad == '0 || bn == '0) begin
               ctl.kind = KIND_CONST; ctl.status = STATUS_ZERO_DEN;
            end
         end
         CMD_EQ, CMD_LT: begin
            ctl.kind = (command == CMD_EQ) ? KIND_EQ : KIND_LT;
            x0 = an; y0 = bd; ctl.neg0 = an_n ^ ad_n;
            x1 = bn; y1 = ad; ctl.neg1 = bn_n;
            ctl.use1 = 1'b1;
            if (ad == '0 || bd == '0) begin
               ctl.kind = KIND_CONST; ctl.status = STATUS_ZERO_DEN;
            end
         end
         default: begin
            ctl.kind = KIND_CONST;
         end
      endcase
   end

   assign entry = {ctl, x0, y0, x1, y1, x2, y2};

endmodule

// File: sv/rau_mul.sv
module rau_mul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           load,
   input  logic           step,
   input  logic [W-1:0]   x,
   input  logic [W-1:0]   y,
   output logic [2*W-1:0] product
);

   logic [2*W-1:0] mcand_ff, acc_ff;
   logic [W-1:0]   mplier_ff;

   assign product = acc_ff;

   // Shift-and-add: one multiplier bit per step, W steps per product.
   always_ff @(posedge clock) begin
      if (load) begin
         mcand_ff  <= {{W{1'b0}}, x};
         mplier_ff <= y;
         acc_ff    <= '0;
      end else if (step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[2*W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[W-1:1]};
      end
   end

endmodule

// File: sv/rau_back.sv
module rau_back import rau_pkg::*; #(
   parameter int W = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  logic [$bits(ctl_type)+6*W-1:0] q_entry,
   output logic                           q_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [W-1:0]            rsp_res_num,
   output logic        [W-2:0]            rsp_res_den,
   output logic                           rsp_compare_true,
   output logic        [1:0]              rsp_status
);

   localparam int MW = 2 * W;
   localparam int CW = $clog2(MW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_SUM, S_GEVEN, S_GODD, S_GLOOP, S_GSCALE, S_DIV, S_CHECK, S_OUT
   } state_type;

   state_type       state_ff, state_in;
   ctl_type         ctl_ff, ctl_in, q_ctl;
   logic [CW-1:0]   cnt_ff, cnt_in, k_ff, k_in;
   logic            neg_ff, neg_in;
   logic [MW-1:0]   nm_ff, nm_in, dm_ff, dm_in;
   logic [MW-1:0]   ga_ff, ga_in, gb_ff, gb_in;
   logic [MW-1:0]   qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [W-1:0]    snum_ff, snum_in;
   logic [W-2:0]    sden_ff, sden_in;
   logic            scmp_ff, scmp_in;
   logic [1:0]      sst_ff, sst_in;
   logic            ovalid_ff, ovalid_in;
   logic [W-1:0]    onum_ff, onum_in;
   logic [W-2:0]    oden_ff, oden_in;
   logic            ocmp_ff, ocmp_in;
   logic [1:0]      ost_ff, ost_in;

   logic [W-1:0]    x0, y0, x1, y1, x2, y2;
   logic [MW-1:0]   p0, p1, p2, p1e;
   logic            mul_load, mul_step, wr;
   logic            s0neg, s1neg;
   logic [MW:0]     sdiff, gdiff, rn_try, rd_try;
   logic [MW-1:0]   rn_sh, rd_sh;
   logic            ovf;
   logic [W-1:0]    lim;

   assign {q_ctl, x0, y0, x1, y1, x2, y2} = q_entry;

   // Three multipliers run in lockstep on the queued cross products.
   assign mul_load = (state_ff == S_IDLE) && !q_empty;
   assign mul_step = (state_ff == S_MUL);

   rau_mul #(.W(W)) u_mul0 (.clock, .load(mul_load), .step(mul_step),
                            .x(x0), .y(y0), .product(p0));
   rau_mul #(.W(W)) u_mul1 (.clock, .load(mul_load), .step(mul_step),
                            .x(x1), .y(y1), .product(p1));
   rau_mul #(.W(W)) u_mul2 (.clock, .load(mul_load), .step(mul_step),
                            .x(x2), .y(y2), .product(p2));

   // Signed sum of the first two products, and the gcd subtraction.
   assign s0neg = ctl_ff.neg0 && (p0 != '0);
   assign s1neg = ctl_ff.neg1 && (p1 != '0);
   assign p1e   = ctl_ff.use1 ? p1 : '0;
   assign sdiff = {1'b0, p0} - {1'b0, p1e};
   assign gdiff = {1'b0, gb_ff} - {1'b0, ga_ff};

   // One restoring division step for numerator and denominator at once.
   assign rn_sh  = {rn_ff[MW-2:0], qn_ff[MW-1]};
   assign rd_sh  = {rd_ff[MW-2:0], qd_ff[MW-1]};
   assign rn_try = {rn_ff[MW-1], rn_sh} - {1'b0, ga_ff};
   assign rd_try = {rd_ff[MW-1], rd_sh} - {1'b0, ga_ff};

   // Range check of the reduced fraction.
   assign lim = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   assign ovf = (qn_ff[MW-1:W] != '0) || (qd_ff[MW-1:W-1] != '0) || (qn_ff[W-1:0] > lim);

   assign wr = (state_ff == S_OUT) && (!ovalid_ff || rsp_pop);
   assign q_pop = mul_load;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      ctl_in = ctl_ff; cnt_in = cnt_ff; k_in = k_ff; neg_in = neg_ff;
      nm_in = nm_ff; dm_in = dm_ff; ga_in = ga_ff; gb_in = gb_ff;
      qn_in = qn_ff; qd_in = qd_ff; rn_in = rn_ff; rd_in = rd_ff;
      snum_in = snum_ff; sden_in = sden_ff; scmp_in = scmp_ff; sst_in = sst_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               ctl_in = q_ctl;
               cnt_in = '0;
               snum_in = '0; sden_in = (W-1)'(1); scmp_in = 1'b0; sst_in = q_ctl.status;
               state_in = (q_ctl.kind == KIND_CONST) ? S_OUT : S_MUL;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            snum_in = '0; sden_in = (W-1)'(1); scmp_in = 1'b0; sst_in = STATUS_OK;
            case (ctl_ff.kind)
               KIND_EQ: begin
                  scmp_in = (s0neg == s1neg) && (p0 == p1);
                  state_in = S_OUT;
               end
               KIND_LT: begin
                  if (s0neg != s1neg) begin
                     scmp_in = s0neg;
                  end else begin
                     scmp_in = s0neg ? (p0 > p1) : (p0 < p1);
                  end
                  state_in = S_OUT;
               end
               default: begin
                  if (s0neg == s1neg) begin
                     nm_in = p0 + p1e; neg_in = s0neg;
                  end else if (!sdiff[MW]) begin
                     nm_in = sdiff[MW-1:0]; neg_in = s0neg;
                  end else begin
                     nm_in = p1e - p0; neg_in = s1neg;
                  end
                  neg_in = neg_in ^ ctl_ff.neg2;
                  dm_in = p2;
                  ga_in = nm_in; gb_in = p2; k_in = '0;
                  state_in = (nm_in == '0) ? S_OUT : S_GEVEN;
               end
            endcase
         end
         S_GEVEN: begin
            if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1; gb_in = gb_ff >> 1; k_in = k_ff + 1'b1;
            end else begin
               state_in = S_GODD;
            end
         end
         S_GODD: begin
            if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else begin
               state_in = S_GLOOP;
            end
         end
         S_GLOOP: begin
            if (gb_ff == '0) begin
               state_in = S_GSCALE;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (gdiff[MW]) begin
               ga_in = gb_ff; gb_in = ga_ff - gb_ff;
            end else begin
               gb_in = gdiff[MW-1:0];
            end
         end
         S_GSCALE: begin
            if (k_ff == '0) begin
               qn_in = nm_ff; qd_in = dm_ff; rn_in = '0; rd_in = '0; cnt_in = '0;
               state_in = S_DIV;
            end else begin
               ga_in = ga_ff << 1; k_in = k_ff - 1'b1;
            end
         end
         S_DIV: begin
            if (!rn_try[MW]) begin
               rn_in = rn_try[MW-1:0]; qn_in = {qn_ff[MW-2:0], 1'b1};
            end else begin
               rn_in = rn_sh; qn_in = {qn_ff[MW-2:0], 1'b0};
            end
            if (!rd_try[MW]) begin
               rd_in = rd_try[MW-1:0]; qd_in = {qd_ff[MW-2:0], 1'b1};
            end else begin
               rd_in = rd_sh; qd_in = {qd_ff[MW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1)) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ovf) begin
               snum_in = '0; sden_in = (W-1)'(1); sst_in = STATUS_OVERFLOW;
            end else begin
               snum_in = neg_ff ? W'(-qn_ff[W-1:0]) : qn_ff[W-1:0];
               sden_in = qd_ff[W-2:0];
               sst_in  = STATUS_OK;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (wr) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds one result while the next item is being worked.
   always_comb begin
      ovalid_in = ovalid_ff && !rsp_pop;
      onum_in = onum_ff; oden_in = oden_ff; ocmp_in = ocmp_ff; ost_in = ost_ff;
      if (wr) begin
         ovalid_in = 1'b1;
         onum_in = snum_ff; oden_in = sden_ff; ocmp_in = scmp_ff; ost_in = sst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
      ctl_ff <= ctl_in; cnt_ff <= cnt_in; k_ff <= k_in; neg_ff <= neg_in;
      nm_ff <= nm_in; dm_ff <= dm_in; ga_ff <= ga_in; gb_ff <= gb_in;
      qn_ff <= qn_in; qd_ff <= qd_in; rn_ff <= rn_in; rd_ff <= rd_in;
      snum_ff <= snum_in; sden_ff <= sden_in; scmp_ff <= scmp_in; sst_ff <= sst_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ocmp_ff <= ocmp_in; ost_ff <= ost_in;
   end

   assign rsp_empty        = !ovalid_ff;
   assign rsp_res_num      = onum_ff;
   assign rsp_res_den      = oden_ff;
   assign rsp_compare_true = ocmp_ff;
   assign rsp_status       = ost_ff;

   // The gcd is never zero while it divides.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (ga_ff != '0))
      else $error("gcd is zero during division");

   // An error result always reads as zero over one.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (wr && sst_ff != STATUS_OK) |-> (snum_ff == '0 && sden_ff == (W-1)'(1) && !scmp_ff))
      else $error("error result is not 0/1");

   // A queued item is taken only when the previous result has left the sequencer.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == S_MUL || state_ff == S_OUT))
      else $error("item taken outside idle");

endmodule

// File: sv/rational_arith_unit.sv
// Exact fraction arithmetic: each item reduces a, forms a+b, a-b, a*b or a/b and reduces it,
// or compares a and b by value. Items are queued two deep behind the input and worked one at
// a time by a sequencer: the three shift-add cross products, then the sum, a data-dependent
// binary gcd (one shift or subtract per cycle), restoring division of numerator and
// denominator by the gcd, then a range check. Compares are decided at the sum; zero-denominator
// and unknown commands go straight to the output. A finished result waits in an output
// register while the next item starts.
module rational_arith_unit import rau_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic        [2:0]           req_command,
   input  logic signed [WORD_BITS-1:0] req_a_num,
   input  logic signed [WORD_BITS-1:0] req_a_den,
   input  logic signed [WORD_BITS-1:0] req_b_num,
   input  logic        [WORD_BITS-2:0] req_b_den,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic signed [WORD_BITS-1:0] rsp_res_num,
   output logic        [WORD_BITS-2:0] rsp_res_den,
   output logic                        rsp_compare_true,
   output logic        [1:0]           rsp_status
);

   localparam int EW = $bits(ctl_type) + 6 * WORD_BITS;
   localparam int QDEPTH = 2;

   logic [EW-1:0] f_entry, q_entry;
   logic          q_empty, q_pop;

   rau_front #(.W(WORD_BITS)) u_front (
      .command(req_command), .a_num(req_a_num), .a_den(req_a_den),
      .b_num(req_b_num), .b_den(req_b_den), .entry(f_entry)
   );

   rau_queue #(.WIDTH(EW), .DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push(req_push), .push_data(f_entry), .full(req_full),
      .pop(q_pop), .head_data(q_entry), .empty(q_empty)
   );

   rau_back #(.W(WORD_BITS)) u_back (
      .clock, .reset, .q_empty, .q_entry, .q_pop,
      .rsp_empty, .rsp_pop, .rsp_res_num, .rsp_res_den, .rsp_compare_true, .rsp_status
   );

endmodule

// File: test/rational_arith_unit_test.sv
module rational_arith_unit_test import rau_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1300;
   localparam logic [2:0] CMD_UNDEFINED = 3'd7;

   // One fraction result as seen on the response ports.
   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               cmp;
      logic [1:0]         status;
   } fraction_result_type;

   // One row of the directed stimulus; check_fixed selects the typed-in result.
   typedef struct {
      logic [2:0]          command;
      logic signed [31:0]  a_num;
      logic signed [31:0]  a_den;
      logic signed [31:0]  b_num;
      logic [30:0]         b_den;
      bit                  check_fixed;
      fraction_result_type fixed;
   } stimulus_row_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [2:0] req_command;
   logic signed [31:0] req_a_num;
   logic signed [31:0] req_a_den;
   logic signed [31:0] req_b_num;
   logic [30:0] req_b_den;
   logic rsp_empty;
   logic rsp_pop;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic rsp_compare_true;
   logic [1:0] rsp_status;

   fraction_result_type pending_results[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stimulus_done = 0;

   rational_arith_unit uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_command(req_command),
      .req_a_num(req_a_num),
      .req_a_den(req_a_den),
      .req_b_num(req_b_num),
      .req_b_den(req_b_den),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_res_num(rsp_res_num),
      .rsp_res_den(rsp_res_den),
      .rsp_compare_true(rsp_compare_true),
      .rsp_status(rsp_status)
   );

   // Clock generation.
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic fraction_result_type make_result(logic signed [31:0] num,
                                                        logic [30:0] den,
                                                        logic cmp, logic [1:0] status);
      fraction_result_type r;
      r.num = num;
      r.den = den;
      r.cmp = cmp;
      r.status = status;
      return r;
   endfunction

   // Euclid's gcd on wide magnitudes; both operands are nonzero.
   function automatic logic [127:0] wide_gcd(logic [127:0] x, logic [127:0] y);
      logic [127:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Reduces num/den with signs carried apart and checks that it fits.
   function automatic fraction_result_type reduce_fraction(bit num_neg, logic [127:0] num_mag,
                                                           bit den_neg, logic [127:0] den_mag);
      logic [127:0] g;
      logic [127:0] qn;
      logic [127:0] qd;
      bit neg;
      if (den_mag == 0) return make_result(0, 1, 0, STATUS_ZERO_DEN);
      if (num_mag == 0) return make_result(0, 1, 0, STATUS_OK);
      neg = num_neg != den_neg;
      g = wide_gcd(num_mag, den_mag);
      qn = num_mag / g;
      qd = den_mag / g;
      if (qd > 128'h7fff_ffff || qn > (neg ? 128'h8000_0000 : 128'h7fff_ffff))
         return make_result(0, 1, 0, STATUS_OVERFLOW);
      return make_result(neg ? -qn[31:0] : qn[31:0], qd[30:0], 0, STATUS_OK);
   endfunction

   // Computes the expected result of one command on signed 128-bit values.
   function automatic fraction_result_type predict_fraction(logic [2:0] command,
         logic signed [31:0] a_num, logic signed [31:0] a_den,
         logic signed [31:0] b_num, logic [30:0] b_den);
      logic signed [127:0] an;
      logic signed [127:0] ad;
      logic signed [127:0] bn;
      logic signed [127:0] bd;
      logic signed [127:0] n;
      logic signed [127:0] d;
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      an = a_num;
      ad = a_den;
      bn = b_num;
      bd = {97'd0, b_den};
      case (command)
         CMD_REDUCE: begin
            n = an;
            d = ad;
         end
         CMD_ADD, CMD_SUB: begin
            n = (command == CMD_ADD) ? an * bd + bn * ad : an * bd - bn * ad;
            d = ad * bd;
         end
         CMD_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         CMD_DIV: begin
            n = an * bd;
            d = ad * bn;
         end
         CMD_EQ, CMD_LT: begin
            if (ad == 0 || bd == 0) return make_result(0, 1, 0, STATUS_ZERO_DEN);
            // Compare an/ad with bn/bd using a positive denominator for a.
            lhs = (ad < 0) ? -an * bd : an * bd;
            rhs = (ad < 0) ? -bn * ad : bn * ad;
            return make_result(0, 1, (command == CMD_EQ) ? (lhs == rhs) : (lhs < rhs),
                               STATUS_OK);
         end
         default: return make_result(0, 1, 0, STATUS_OK);
      endcase
      return reduce_fraction(n < 0, (n < 0) ? -n : n, d < 0, (d < 0) ? -d : d);
   endfunction

   // Random gap: mostly none or short, sometimes long.
   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // Random 32-bit operand, biased toward small values and extremes.
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom;
         2: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
         3: return ($urandom_range(0, 1) ? -1 : 1) * $signed({16'd0, 16'($urandom)});
         default: return $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   // Sends one item and stores its expected result; push stays high across
   // back-to-back items and drops only for a gap.
   task automatic send_item(input logic [2:0] command, input logic signed [31:0] a_num,
                            input logic signed [31:0] a_den, input logic signed [31:0] b_num,
                            input logic [30:0] b_den, input bit check_fixed,
                            input fraction_result_type fixed);
      int gap;
      fraction_result_type predicted;
      gap = gap_length();
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_command <= command;
      req_a_num <= a_num;
      req_a_den <= a_den;
      req_b_num <= b_num;
      req_b_den <= b_den;
      do @(posedge clock); while (req_full);
      predicted = predict_fraction(command, a_num, a_den, b_num, b_den);
      if (check_fixed) begin
         if (predicted != fixed) report_mismatch("directed row vs predictor", command, command);
         pending_results.insert(pending_results.size(), fixed);
      end else begin
         pending_results.insert(pending_results.size(), predicted);
      end
   endtask

   // Stimulus: directed rows, then random items.
   initial begin
      stimulus_row_type rows[$];
      fraction_result_type none;
      logic [2:0] command;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic [30:0] b_den;
      int pick;
      none = make_result(0, 1, 0, STATUS_OK);
      rows = '{
         '{CMD_REDUCE, 6, 4, 0, 1, 1, make_result(3, 2, 0, STATUS_OK)},
         '{CMD_REDUCE, 5, -10, 0, 1, 1, make_result(-1, 2, 0, STATUS_OK)},
         '{CMD_REDUCE, 0, -7, 0, 1, 1, make_result(0, 1, 0, STATUS_OK)},
         '{CMD_REDUCE, 3, 0, 0, 1, 1, make_result(0, 1, 0, STATUS_ZERO_DEN)},
         '{CMD_REDUCE, 32'sh8000_0000, -1, 0, 1, 1, make_result(0, 1, 0, STATUS_OVERFLOW)},
         '{CMD_REDUCE, 32'sh8000_0000, 1, 0, 1, 1,
           make_result(32'sh8000_0000, 1, 0, STATUS_OK)},
         '{CMD_REDUCE, 1, 32'sh8000_0000, 0, 1, 1, make_result(0, 1, 0, STATUS_OVERFLOW)},
         '{CMD_ADD, 1, 2, 1, 3, 0, none},
         '{CMD_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1, 1,
           make_result(0, 1, 0, STATUS_OVERFLOW)},
         '{CMD_ADD, 1, 2, 1, 0, 1, make_result(0, 1, 0, STATUS_ZERO_DEN)},
         '{CMD_SUB, 1, 3, 1, 3, 1, make_result(0, 1, 0, STATUS_OK)},
         '{CMD_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff, 0, none},
         '{CMD_MUL, -2, 3, 3, 4, 0, none},
         '{CMD_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1, 1,
           make_result(0, 1, 0, STATUS_OVERFLOW)},
         '{CMD_DIV, 1, 2, 0, 5, 1, make_result(0, 1, 0, STATUS_ZERO_DEN)},
         '{CMD_DIV, 3, -4, -9, 8, 0, none},
         '{CMD_EQ, 2, 4, 1, 2, 1, make_result(0, 1, 1, STATUS_OK)},
         '{CMD_EQ, -2, -4, 1, 2, 1, make_result(0, 1, 1, STATUS_OK)},
         '{CMD_EQ, 1, 0, 1, 2, 1, make_result(0, 1, 0, STATUS_ZERO_DEN)},
         '{CMD_LT, 1, -3, 0, 1, 1, make_result(0, 1, 1, STATUS_OK)},
         '{CMD_LT, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 0, none},
         '{CMD_LT, 1, 2, 1, 0, 1, make_result(0, 1, 0, STATUS_ZERO_DEN)},
         '{CMD_UNDEFINED, -1, -1, -1, 31'h7fff_ffff, 1, make_result(0, 1, 0, STATUS_OK)}
      };
      req_push <= 0;
      req_command <= CMD_REDUCE;
      req_a_num <= 0;
      req_a_den <= 1;
      req_b_num <= 0;
      req_b_den <= 1;
      reset <= 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i])
         send_item(rows[i].command, rows[i].a_num, rows[i].a_den, rows[i].b_num,
                   rows[i].b_den, rows[i].check_fixed, rows[i].fixed);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         command = $urandom_range(0, 15) == 0 ? CMD_UNDEFINED : 3'($urandom_range(0, 6));
         a_num = random_word();
         a_den = random_word();
         b_num = random_word();
         b_den = 31'(random_word());
         // Zero denominators now and then, otherwise mostly well formed.
         pick = $urandom_range(0, 19);
         if (pick == 0) a_den = 0;
         else if (pick == 1) b_den = 0;
         else if (a_den == 0) a_den = 1;
         if (pick > 1 && b_den == 0) b_den = 1;
         send_item(command, a_num, a_den, b_num, b_den, 0, none);
      end
      req_push <= 0;
      stimulus_done = 1;
   end

   // Result side: random pops and comparison against the oldest expectation.
   initial begin
      fraction_result_type want;
      int gap;
      rsp_pop <= 0;
      @(negedge reset);
      forever begin
         gap = gap_length();
         if (gap > 0) begin
            rsp_pop <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1;
         do @(posedge clock); while (rsp_empty);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_res_num !== want.num) report_mismatch("res_num", rsp_res_num, want.num);
            if (rsp_res_den !== want.den) report_mismatch("res_den", rsp_res_den, want.den);
            if (rsp_compare_true !== want.cmp)
               report_mismatch("compare_true", rsp_compare_true, want.cmp);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // End of run: drain, settle, then give the verdict, or report an error on a watchdog timeout.
   initial begin
      @(negedge reset);
      while (!(stimulus_done && pending_results.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
      end else begin
         repeat (600) @(posedge clock);
         if (error_count == 0) $display("RESULT: OK");
         else $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
